[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file rpq_checker.sv.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle, checked outside reset
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// expr must never hold outside reset
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("assertion failed: forbidden condition");

`endif

[rtl/core/rpq_pkg.sv]
// Package for the RGB565 palette quantizer: widths, palette table, widening functions.
// No dependencies; used by every module of the block.
package rpq_pkg;

   localparam int PALETTE_ENTRIES = 16;   // entries searched, 2..16
   localparam int PAL_TABLE_SIZE  = 16;
   localparam int IDX_W           = 4;
   localparam int COMP_W          = 8;
   localparam int DIST_W          = 18;   // 3 * 255^2 fits in 18 bits
   localparam int PIX_W           = 16;
   // unpack stage plus two stages per cell
   localparam int LATENCY         = 1 + 2 * PALETTE_ENTRIES;

   localparam logic [PIX_W-1:0] PAL_COLORS [PAL_TABLE_SIZE] = '{
      16'h0000, 16'h8410, 16'h001F, 16'h051F, 16'h07E0, 16'h07E0, 16'h07FF, 16'h06DF,
      16'hF800, 16'hF8B2, 16'hF81F, 16'h781F, 16'hFFE0, 16'hA145, 16'hFFFF, 16'hC618
   };

   typedef struct packed {
      logic [COMP_W-1:0] r;
      logic [COMP_W-1:0] g;
      logic [COMP_W-1:0] b;
      logic [DIST_W-1:0] best_dist;
      logic [IDX_W-1:0]  best_idx;
   } token_type;

   // round(v*255/31) through a reciprocal multiply, exact for all 5-bit v
   function automatic logic [COMP_W-1:0] widen5(input logic [4:0] v);
      logic [15:0] t;
      t = 16'(v) * 16'd527 + 16'd23;
      return t[13:6];
   endfunction

   // round(v*255/63), exact for all 6-bit v
   function automatic logic [COMP_W-1:0] widen6(input logic [5:0] v);
      logic [15:0] t;
      t = 16'(v) * 16'd259 + 16'd33;
      return t[13:6];
   endfunction

   function automatic logic [COMP_W-1:0] pal_r(input logic [IDX_W-1:0] idx);
      logic [PIX_W-1:0] c;
      c = PAL_COLORS[idx];
      return widen5(c[15:11]);
   endfunction

   function automatic logic [COMP_W-1:0] pal_g(input logic [IDX_W-1:0] idx);
      logic [PIX_W-1:0] c;
      c = PAL_COLORS[idx];
      return widen6(c[10:5]);
   endfunction

   function automatic logic [COMP_W-1:0] pal_b(input logic [IDX_W-1:0] idx);
      logic [PIX_W-1:0] c;
      c = PAL_COLORS[idx];
      return widen5(c[4:0]);
   endfunction

endpackage

[rtl/core/rpq_unpack.sv]
// Entry stage: splits an RGB565 request into 8-bit components and seeds the search token.
// Depends on rpq_pkg.
module rpq_unpack (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  logic [rpq_pkg::PIX_W-1:0]         pixel_in,
   output logic                              valid_out,
   output rpq_pkg::token_type                tok_out
);

   logic               valid_ff;
   rpq_pkg::token_type tok_ff, tok_in;

   always_comb begin
      tok_in.r         = rpq_pkg::widen5(pixel_in[15:11]);
      tok_in.g         = rpq_pkg::widen6(pixel_in[10:5]);
      tok_in.b         = rpq_pkg::widen5(pixel_in[4:0]);
      // larger than any real distance, so the first cell always takes over
      tok_in.best_dist = '1;
      tok_in.best_idx  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign valid_out = valid_ff;
   assign tok_out   = tok_ff;

endmodule

[rtl/core/rpq_cell.sv]
// One cell of the search chain: compares the passing pixel against one palette entry.
// Two register stages (squares, then sum and compare). Depends on rpq_pkg.
module rpq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rpq_pkg::IDX_W-1:0]         entry_idx,
   input  logic                              valid_in,
   input  rpq_pkg::token_type                tok_in,
   output logic                              valid_out,
   output rpq_pkg::token_type                tok_out
);

   localparam int SQ_W = 2 * rpq_pkg::COMP_W;

   logic [rpq_pkg::COMP_W-1:0] pr, pg, pb;
   logic [rpq_pkg::COMP_W-1:0] dr, dg, db;
   logic [SQ_W-1:0]            sq_r_in, sq_g_in, sq_b_in;
   logic [SQ_W-1:0]            sq_r_ff, sq_g_ff, sq_b_ff;
   logic                       s1_valid_ff, s2_valid_ff;
   rpq_pkg::token_type         s1_tok_ff, s2_tok_ff, s2_tok_in;
   logic [rpq_pkg::DIST_W-1:0] sum_dist;

   assign pr = rpq_pkg::pal_r(entry_idx);
   assign pg = rpq_pkg::pal_g(entry_idx);
   assign pb = rpq_pkg::pal_b(entry_idx);

   assign dr = (tok_in.r >= pr) ? tok_in.r - pr : pr - tok_in.r;
   assign dg = (tok_in.g >= pg) ? tok_in.g - pg : pg - tok_in.g;
   assign db = (tok_in.b >= pb) ? tok_in.b - pb : pb - tok_in.b;

   assign sq_r_in = SQ_W'(dr) * SQ_W'(dr);
   assign sq_g_in = SQ_W'(dg) * SQ_W'(dg);
   assign sq_b_in = SQ_W'(db) * SQ_W'(db);

   assign sum_dist = rpq_pkg::DIST_W'(sq_r_ff) + rpq_pkg::DIST_W'(sq_g_ff)
                   + rpq_pkg::DIST_W'(sq_b_ff);

   // strict less-than keeps the lower index on a tie
   always_comb begin
      s2_tok_in = s1_tok_ff;
      if (sum_dist < s1_tok_ff.best_dist) begin
         s2_tok_in.best_dist = sum_dist;
         s2_tok_in.best_idx  = entry_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_r_ff   <= sq_r_in;
      sq_g_ff   <= sq_g_in;
      sq_b_ff   <= sq_b_in;
      s1_tok_ff <= tok_in;
      s2_tok_ff <= s2_tok_in;
   end

   assign valid_out = s2_valid_ff;
   assign tok_out   = s2_tok_ff;

endmodule

[rtl/core/rgb565_palette_quantizer.sv]
// Top level of the RGB565 nearest-color palette quantizer.
// Depends on rpq_pkg, rpq_unpack and rpq_cell.
//
// Accepts one request per clock (busy never rises) and returns one palette
// index per request, in order, on rsp_palette_index with rsp_valid high for one
// cycle. The path is one unpack stage, then a chain of one cell per palette
// entry, each cell two stages deep. The receiver cannot stall the output;
// results must be taken when rsp_valid is high. Ties go to the lower index, so
// entry 5 (a copy of entry 4) is never reported.
module rgb565_palette_quantizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rpq_pkg::PIX_W-1:0]         req_pixel_rgb565,
   output logic                              rsp_valid,
   output logic [rpq_pkg::IDX_W-1:0]         rsp_palette_index
);

   localparam int N = rpq_pkg::PALETTE_ENTRIES;

   logic               chain_valid [N+1];
   rpq_pkg::token_type chain_tok   [N+1];

   assign busy = 1'b0;

   rpq_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start & ~busy),
      .pixel_in  (req_pixel_rgb565),
      .valid_out (chain_valid[0]),
      .tok_out   (chain_tok[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      rpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .entry_idx (rpq_pkg::IDX_W'(i)),
         .valid_in  (chain_valid[i]),
         .tok_in    (chain_tok[i]),
         .valid_out (chain_valid[i+1]),
         .tok_out   (chain_tok[i+1])
      );
   end

   assign rsp_valid         = chain_valid[N];
   assign rsp_palette_index = chain_tok[N].best_idx;

endmodule

[rtl/core/rpq_checker.sv]
// Port-level checker for rgb565_palette_quantizer, attached by bind.
// Depends on rpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [rpq_pkg::PIX_W-1:0]         req_pixel_rgb565,
   input logic                              rsp_valid,
   input logic [rpq_pkg::IDX_W-1:0]         rsp_palette_index
);

   `ASSERT_NEVER(a_never_busy, busy)
   `ASSERT_IMP(a_rsp_has_request, rsp_valid,
               $past(start & ~busy, rpq_pkg::LATENCY))
   `ASSERT_IMP(a_index_in_range, rsp_valid,
               32'(rsp_palette_index) < rpq_pkg::PALETTE_ENTRIES)
   `ASSERT_IMP(a_no_duplicate_entry, rsp_valid, rsp_palette_index != rpq_pkg::IDX_W'(5))
   `ASSERT_IMP(a_black_maps_to_zero,
               rsp_valid && $past(start & ~busy & (req_pixel_rgb565 == '0), rpq_pkg::LATENCY),
               rsp_palette_index == '0)

endmodule

bind rgb565_palette_quantizer rpq_checker u_rpq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_pixel_rgb565  (req_pixel_rgb565),
   .rsp_valid         (rsp_valid),
   .rsp_palette_index (rsp_palette_index)
);
